### rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// shared types and packing constants for the generation slot cache
// ----------------------------------------------------------------------------
package gsc_pkg;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned GEN_W   = 64;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SLOT_W  = 4;

  // request word: resource_id, payload, oldest_live_generation, current_generation
  localparam int unsigned IN_W  = ID_W + DATA_W + GEN_W + GEN_W;
  // result word: slot_index, hit, evicted, failed, change_count, zero fill to bytes
  localparam int unsigned RES_W = SLOT_W + 3 + COUNT_W;
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [GEN_W-1:0]  generation;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

### rtl/gsc_table.sv
// ----------------------------------------------------------------------------
// gsc_table
// slot memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module gsc_table
  import gsc_pkg::*;
#(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
  end

endmodule

### rtl/generation_slot_cache_unit.sv
// ----------------------------------------------------------------------------
// generation_slot_cache_unit
// slot cache with lookup, lowest-free insertion and generation based eviction
// ----------------------------------------------------------------------------
// One request is handled at a time. After a request is taken the block reads
// the occupied slots one per cycle from a single-port-read slot memory,
// looking for the id and tracking the eviction candidate (smallest id whose
// generation is below oldest_live_generation). A hit stops the scan at the
// matching slot; a miss reads every filled slot, and an empty table skips the
// scan. Slots are always occupied from slot 0 upward (an eviction refills its
// slot at once), so a fill count stands in for the used flags: no clearing
// pass is needed after reset. The result sits in an output register, so a new
// request is taken while the previous result still waits on the master side.
module generation_slot_cache_unit
  import gsc_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // resource_id, payload, oldest_live_generation, current_generation
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // slot_index, hit, evicted, failed, change_count, zero fill
  output logic [OUT_W-1:0] m_tdata
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_RESULT
  } state_t;

  state_t state;

  // captured request
  logic [ID_W-1:0]   req_id;
  logic [DATA_W-1:0] req_payload;
  logic [GEN_W-1:0]  req_oldest;
  logic [GEN_W-1:0]  req_cur;

  // table bookkeeping
  logic [FW-1:0]      fill;
  logic [COUNT_W-1:0] change_count;

  // scan state
  logic [AW-1:0]   cur_idx;
  logic            vic_valid;
  logic [AW-1:0]   vic_idx;
  logic [ID_W-1:0] vic_id;

  // pending result
  logic [AW-1:0] res_slot;
  logic          res_hit;
  logic          res_evicted;
  logic          res_failed;

  // memory ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;

  logic match;
  logic better;
  logic last;
  logic free;
  logic out_load;
  logic [AW+SLOT_W-1:0] slot_ext;

  assign s_tready = (state == ST_IDLE);

  // compare the entry read for cur_idx against the request
  assign match  = (rd_entry.id == req_id);
  assign better = (rd_entry.generation < req_oldest) &&
                  (!vic_valid || (rd_entry.id < vic_id));
  assign last   = (FW'(cur_idx) == (fill - FW'(1)));
  assign free   = (fill < FW'(SLOTS));

  // next read address runs one ahead of the entry being checked
  always_comb begin
    if (state == ST_SCAN && !last) begin
      rd_addr = cur_idx + AW'(1);
    end else if (state == ST_SCAN) begin
      rd_addr = cur_idx;
    end else begin
      rd_addr = '0;
    end
  end

  // write back: generation refresh on a hit, new entry on a miss
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cur_idx;
    wr_entry = '{payload: req_payload, generation: req_cur, id: req_id};
    unique case (state)
      ST_SCAN: begin
        wr_en            = match;
        wr_entry.payload = rd_entry.payload;
      end
      ST_RESOLVE: begin
        wr_en   = free || vic_valid;
        wr_addr = free ? fill[AW-1:0] : vic_idx;
      end
      ST_IDLE, ST_RESULT: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  gsc_table #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // slot index zero extended; its low SLOT_W bits form the result field
  assign slot_ext = {{SLOT_W{1'b0}}, res_slot};
  assign out_load = (state == ST_RESULT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      change_count <= '0;
      vic_valid    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // result taken and nothing new to load
      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req_id      <= s_tdata[ID_W-1:0];
            req_payload <= s_tdata[ID_W +: DATA_W];
            req_oldest  <= s_tdata[ID_W+DATA_W +: GEN_W];
            req_cur     <= s_tdata[ID_W+DATA_W+GEN_W +: GEN_W];
            vic_valid   <= 1'b0;
            cur_idx     <= '0;
            // empty table: nothing to scan
            state       <= (fill == '0) ? ST_RESOLVE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match) begin
            res_slot    <= cur_idx;
            res_hit     <= 1'b1;
            res_evicted <= 1'b0;
            res_failed  <= 1'b0;
            state       <= ST_RESULT;
          end else begin
            if (better) begin
              vic_valid <= 1'b1;
              vic_idx   <= cur_idx;
              vic_id    <= rd_entry.id;
            end
            if (last) begin
              state <= ST_RESOLVE;
            end else begin
              cur_idx <= cur_idx + AW'(1);
            end
          end
        end
        ST_RESOLVE: begin
          res_hit <= 1'b0;
          priority if (free) begin
            // lowest free slot is the one just past the filled range
            res_slot     <= fill[AW-1:0];
            res_evicted  <= 1'b0;
            res_failed   <= 1'b0;
            fill         <= fill + FW'(1);
            change_count <= change_count + COUNT_W'(1);
          end else if (vic_valid) begin
            // removal and insertion each count as a change
            res_slot     <= vic_idx;
            res_evicted  <= 1'b1;
            res_failed   <= 1'b0;
            change_count <= change_count + COUNT_W'(2);
          end else begin
            res_slot    <= '0;
            res_evicted <= 1'b0;
            res_failed  <= 1'b1;
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_W-RES_W){1'b0}}, change_count, res_failed, res_evicted,
                         res_hit, slot_ext[SLOT_W-1:0]};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(SLOTS))
    else $error("fill count beyond table size");

  // occupancy grows by at most one slot per request and never shrinks
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    ##1 ((fill == $past(fill)) || (fill == $past(fill) + FW'(1))))
    else $error("fill count stepped wrongly");

  // an eviction only happens on a full table
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_evicted) |-> (fill == FW'(SLOTS)))
    else $error("eviction with free slots left");

  // the change counter only moves as a miss is resolved
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != ST_RESOLVE) |-> $stable(change_count))
    else $error("change counter moved outside resolve");

  // a failed request writes nothing and reports slot 0 with no hit or eviction
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_failed) |-> (res_slot == '0 && !res_hit && !res_evicted))
    else $error("failed request with slot or flags set");

endmodule
